FILE: rtl/fa6d_pkg.sv
// Shared types, character constants and the alphabet lookup for the
// six-bit ASCII fingerprint decoder. No dependencies.
package fa6d_pkg;

    localparam logic [7:0] CHAR_DOT  = 8'h2e;  // '.'
    localparam logic [7:0] CHAR_PLUS = 8'h2b;  // '+'
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UZ   = 8'h5a;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LZ   = 8'h7a;
    localparam logic [7:0] CHAR_PAD1 = 8'h31;  // '1'
    localparam logic [7:0] CHAR_PAD2 = 8'h32;  // '2'
    localparam logic [7:0] CHAR_PAD3 = 8'h33;  // '3'

    localparam logic [7:0] OFS_DIGIT = 8'd2;
    localparam logic [7:0] OFS_UPPER = 8'd12;
    localparam logic [7:0] OFS_LOWER = 8'd38;

    // Byte counts carried by a burst
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // One burst of up to three result words produced by a single character
    typedef struct packed {
        logic [23:0] bytes;     // first word in [23:16]
        logic [1:0]  cnt;       // number of words, one to three
        logic        is_data;   // words carry decoded bytes
        logic        eov;       // last word of the burst ends the vector
        logic        err;       // format error marker
    } burst_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_vector;
        logic       format_error;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } code_t;

    // Map an ASCII character to its six-bit code
    function automatic code_t code_of(logic [7:0] c);
        code_t      r;
        logic [7:0] t;
        r = '0;
        t = '0;
        if (c == CHAR_DOT)
        begin
            r.hit = 1'b1;
        end
        else if (c == CHAR_PLUS)
        begin
            r.hit = 1'b1;
            t     = 8'd1;
        end
        else if (c >= CHAR_0 && c <= CHAR_9)
        begin
            r.hit = 1'b1;
            t     = c - CHAR_0 + OFS_DIGIT;
        end
        else if (c >= CHAR_UA && c <= CHAR_UZ)
        begin
            r.hit = 1'b1;
            t     = c - CHAR_UA + OFS_UPPER;
        end
        else if (c >= CHAR_LA && c <= CHAR_LZ)
        begin
            r.hit = 1'b1;
            t     = c - CHAR_LA + OFS_LOWER;
        end
        r.code = t[5:0];
        return r;
    endfunction

endpackage

FILE: rtl/fa6d_if.sv
// Valid/ready channel interfaces for the character input and the byte output.
// No dependencies.
interface fa6d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       is_pad_marker;

    modport source (output valid, output ascii_char, output is_pad_marker, input ready);
    modport sink   (input valid, input ascii_char, input is_pad_marker, output ready);
endinterface

interface fa6d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_vector;
    logic       format_error;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_vector, output format_error, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_vector, input format_error, output ready);
endinterface

FILE: rtl/fa6d_burst_fifo.sv
// Burst queue and word serializer: holds bursts of up to three result words
// and sends them out one word per cycle while out_ready is high. Depends on fa6d_pkg.
module fa6d_burst_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fa6d_pkg::burst_t  push_rec,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output fa6d_pkg::result_t out_word
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fa6d_pkg::burst_t  mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [1:0]        sel_reg, sel_next;
    fa6d_pkg::burst_t  head;
    logic              last_word;
    logic              pop;

    assign head      = mem_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign last_word = (sel_reg == head.cnt - 2'd1);
    assign pop       = out_valid && out_ready && last_word;

    always_comb
    begin
        out_word.byte_valid    = head.is_data;
        out_word.format_error  = head.err;
        out_word.end_of_vector = head.eov && last_word;
        case (sel_reg)
            2'd0:    out_word.data_byte = head.bytes[23:16];
            2'd1:    out_word.data_byte = head.bytes[15:8];
            default: out_word.data_byte = head.bytes[7:0];
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sel_next    = sel_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (out_valid && out_ready)
        begin
            // advance within the burst, drop it after its last word
            if (last_word)
            begin
                sel_next    = '0;
                rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            else
            begin
                sel_next = sel_reg + 2'd1;
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

FILE: rtl/fingerprint_ascii_six_bit_decoder_core.sv
// Top level of the six-bit ASCII fingerprint decoder: group packing state
// and pad handling. Depends on fa6d_pkg, fa6d_if and fa6d_burst_fifo.

// One character word is accepted per cycle whenever the burst queue has a
// free slot; the group state updates in that same cycle and any bytes the
// character releases are written as one burst into a queue of QUEUE_DEPTH
// bursts. Results leave one word per cycle from the head of that queue
// while the output is ready, one word per released byte; since four data
// characters release three bytes, a steady data stream runs at one
// character per cycle, output back-pressure absorbed until the queue fills.
// Characters outside the alphabet repeat the previous code of their group
// (zero at the start of a group). The pad word ends the string and returns
// all group state to reset; a bad pad or a pad in a partial group yields a
// single error word with end_of_vector set.
module fingerprint_ascii_six_bit_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    fa6d_char_if.sink        char_ch,
    fa6d_byte_if.source      byte_ch
);
    logic [23:0]        group_bits_reg, group_bits_next;
    logic [1:0]         chars_reg, chars_next;
    logic               complete_reg, complete_next;
    logic [5:0]         prev_reg, prev_next;

    fa6d_pkg::burst_t   rec;
    fa6d_pkg::result_t  word;
    fa6d_pkg::code_t    cd;
    logic               rec_push;
    logic               q_full;
    logic               in_fire;
    logic [1:0]         pad_cnt;
    logic [23:0]        base_bits;
    logic [5:0]         prev_base;

    assign char_ch.ready = !q_full;
    assign in_fire       = char_ch.valid && char_ch.ready;
    assign cd            = fa6d_pkg::code_of(char_ch.ascii_char);

    always_comb
    begin
        unique case (char_ch.ascii_char)
            fa6d_pkg::CHAR_PAD1: pad_cnt = fa6d_pkg::CNT_ONE;
            fa6d_pkg::CHAR_PAD2: pad_cnt = fa6d_pkg::CNT_TWO;
            fa6d_pkg::CHAR_PAD3: pad_cnt = fa6d_pkg::CNT_THREE;
            default:             pad_cnt = 2'd0;
        endcase
    end

    always_comb
    begin
        group_bits_next = group_bits_reg;
        chars_next      = chars_reg;
        complete_next   = complete_reg;
        prev_next       = prev_reg;
        rec_push        = 1'b0;
        rec.bytes       = group_bits_reg;
        rec.cnt         = fa6d_pkg::CNT_THREE;
        rec.is_data     = 1'b1;
        rec.eov         = 1'b0;
        rec.err         = 1'b0;
        base_bits       = group_bits_reg;
        prev_base       = (chars_reg == 2'd0) ? 6'd0 : prev_reg;

        if (char_ch.is_pad_marker)
        begin
            // every pad yields exactly one burst, then clear all group state
            rec_push = 1'b1;
            rec.eov  = 1'b1;
            if (pad_cnt == 2'd0 || chars_reg != 2'd0)
            begin
                rec.bytes   = '0;
                rec.cnt     = fa6d_pkg::CNT_ONE;
                rec.is_data = 1'b0;
                rec.err     = 1'b1;
            end
            else if (complete_reg)
            begin
                rec.cnt = pad_cnt;
            end
            else
            begin
                // nothing pending: pad three is an empty end marker
                rec.bytes   = '0;
                rec.cnt     = fa6d_pkg::CNT_ONE;
                rec.is_data = 1'b0;
                rec.err     = (pad_cnt != fa6d_pkg::CNT_THREE);
            end
            group_bits_next = '0;
            chars_next      = '0;
            complete_next   = 1'b0;
            prev_next       = '0;
        end
        else
        begin
            if (complete_reg)
            begin
                // release the held group before starting a new one
                rec_push  = 1'b1;
                base_bits = '0;
            end
            prev_next       = cd.hit ? cd.code : prev_base;
            group_bits_next = {base_bits[17:0], prev_next};
            chars_next      = chars_reg + 2'd1;
            complete_next   = (chars_reg == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg <= '0;
            chars_reg      <= '0;
            complete_reg   <= 1'b0;
            prev_reg       <= '0;
        end
        else if (in_fire)
        begin
            group_bits_reg <= group_bits_next;
            chars_reg      <= chars_next;
            complete_reg   <= complete_next;
            prev_reg       <= prev_next;
        end
    end

    fa6d_burst_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire && rec_push),
        .push_rec  (rec),
        .full      (q_full),
        .out_valid (byte_ch.valid),
        .out_ready (byte_ch.ready),
        .out_word  (word)
    );

    assign byte_ch.data_byte     = word.data_byte;
    assign byte_ch.byte_valid    = word.byte_valid;
    assign byte_ch.end_of_vector = word.end_of_vector;
    assign byte_ch.format_error  = word.format_error;

endmodule

FILE: rtl/fa6d_checker.sv
// Port-level assertions for the six-bit ASCII fingerprint decoder, bound to
// the top level. Depends on fingerprint_ascii_six_bit_decoder_core.
module fa6d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       end_of_vector,
    input logic       format_error
);
    // hold a stalled word
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(data_byte) && $stable(end_of_vector))
        else $error("output word changed while stalled");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && format_error |-> end_of_vector && !byte_valid && data_byte == 8'd0)
        else $error("error word malformed");

    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> end_of_vector && data_byte == 8'd0)
        else $error("non-data word does not end the vector");
endmodule

bind fingerprint_ascii_six_bit_decoder_core fa6d_checker u_fa6d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (byte_ch.valid),
    .out_ready     (byte_ch.ready),
    .data_byte     (byte_ch.data_byte),
    .byte_valid    (byte_ch.byte_valid),
    .end_of_vector (byte_ch.end_of_vector),
    .format_error  (byte_ch.format_error)
);
